### hdl/tssg_pkg.sv
// Shared types, constants and the sequencer program of the triangle
// stretch/shear gradient core. No dependencies.
package tssg_pkg;

    // Triangle jobs buffered between the front and the back
    localparam int QUEUE_DEPTH = 2;

    // Scratch register file of the back part
    localparam int RF_AW    = 6;
    localparam int RF_DEPTH = 2 ** RF_AW;

    // Sequencer program store
    localparam int UC_AW    = 7;
    localparam int UC_DEPTH = 2 ** UC_AW;

    localparam logic [30:0] CFG_ONE = 31'd65536;

    typedef logic [RF_AW-1:0] t_raddr;
    typedef logic [UC_AW-1:0] t_upc;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_STRETCH_K = 2'd0,
        CFG_SHEAR_K   = 2'd1,
        CFG_REST_U    = 2'd2,
        CFG_REST_V    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [30:0] ks;
        logic [30:0] kh;
        logic [30:0] su;
        logic [30:0] sv;
    } t_cfg;

    // One closed triangle: pos[k*3+c] is vertex k, component c
    typedef struct packed {
        logic [8:0][31:0]  pos;
        logic [2:0][15:0]  node;
        logic [3:0][31:0]  inv;
        logic [30:0]       area;
    } t_job;

    typedef enum logic [3:0] {
        OP_LD, OP_ADD, OP_SUB, OP_NSUB, OP_MUL,
        OP_SQ0, OP_SQA, OP_SQRT, OP_DIV, OP_END
    } t_op;

    typedef struct packed {
        t_op    op;
        t_raddr dst;
        t_raddr a;
        t_raddr b;
    } t_uop;

    typedef t_uop [UC_DEPTH-1:0] t_ucode;

    typedef enum logic [2:0] {
        BS_IDLE, BS_FETCH, BS_EXEC, BS_MULW, BS_DIV, BS_SQRT, BS_DONE
    } t_bstate;

    // Register file map
    localparam t_raddr RA_P0   = 6'd0;
    localparam t_raddr RA_P1   = 6'd3;
    localparam t_raddr RA_P2   = 6'd6;
    localparam t_raddr RA_I00  = 6'd9;
    localparam t_raddr RA_I01  = 6'd10;
    localparam t_raddr RA_I10  = 6'd11;
    localparam t_raddr RA_I11  = 6'd12;
    localparam t_raddr RA_AREA = 6'd13;
    localparam t_raddr RA_SU   = 6'd14;
    localparam t_raddr RA_SV   = 6'd15;
    localparam t_raddr RA_KS   = 6'd16;
    localparam t_raddr RA_KH   = 6'd17;
    localparam t_raddr RA_E1   = 6'd18;
    localparam t_raddr RA_E2   = 6'd21;
    localparam t_raddr RA_F1   = 6'd24;
    localparam t_raddr RA_F2   = 6'd27;
    localparam t_raddr RA_T1   = 6'd30;
    localparam t_raddr RA_T2   = 6'd31;
    localparam t_raddr RA_N1   = 6'd32;
    localparam t_raddr RA_N2   = 6'd33;
    localparam t_raddr RA_C0   = 6'd34;
    localparam t_raddr RA_C1   = 6'd35;
    localparam t_raddr RA_DOT  = 6'd36;
    localparam t_raddr RA_C2   = 6'd37;
    localparam t_raddr RA_U1   = 6'd38;
    localparam t_raddr RA_U2   = 6'd41;
    localparam t_raddr RA_CS0  = 6'd44;
    localparam t_raddr RA_CS1  = 6'd45;
    localparam t_raddr RA_CH   = 6'd46;
    localparam t_raddr RA_G1   = 6'd47;
    localparam t_raddr RA_G2   = 6'd50;
    localparam t_raddr RA_GR1  = 6'd53;
    localparam t_raddr RA_GR2  = 6'd56;
    localparam t_raddr RA_GR0  = 6'd59;

    // Saturate to 32 bits signed; bit 32 flags a clip
    function automatic logic [32:0] sat32(input logic signed [48:0] v);
        if (v > 49'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (v < -49'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

    function automatic t_uop mk(t_op op, int d, int a, int b);
        return '{op: op, dst: t_raddr'(d), a: t_raddr'(a), b: t_raddr'(b)};
    endfunction

    // Build the per-triangle program
    function automatic t_ucode build_ucode();
        t_ucode uc;
        int     pc;
        for (int k = 0; k < UC_DEPTH; k++) begin
            uc[k] = mk(OP_END, 0, 0, 0);
        end
        pc = 0;
        // load positions, inverse, area and configuration
        for (int k = 0; k <= int'(RA_KH); k++) begin
            uc[pc] = mk(OP_LD, k, 0, 0); pc = pc + 1;
        end
        // edges
        for (int i = 0; i < 3; i++) begin
            uc[pc] = mk(OP_SUB, RA_E1 + i, RA_P1 + i, RA_P0 + i); pc = pc + 1;
            uc[pc] = mk(OP_SUB, RA_E2 + i, RA_P2 + i, RA_P0 + i); pc = pc + 1;
        end
        // deformation gradient columns
        for (int i = 0; i < 3; i++) begin
            uc[pc] = mk(OP_MUL, RA_T1, RA_E1 + i, RA_I00); pc = pc + 1;
            uc[pc] = mk(OP_MUL, RA_T2, RA_E2 + i, RA_I10); pc = pc + 1;
            uc[pc] = mk(OP_ADD, RA_F1 + i, RA_T1, RA_T2); pc = pc + 1;
            uc[pc] = mk(OP_MUL, RA_T1, RA_E1 + i, RA_I01); pc = pc + 1;
            uc[pc] = mk(OP_MUL, RA_T2, RA_E2 + i, RA_I11); pc = pc + 1;
            uc[pc] = mk(OP_ADD, RA_F2 + i, RA_T1, RA_T2); pc = pc + 1;
        end
        // column lengths
        uc[pc] = mk(OP_SQ0, 0, RA_F1, RA_F1); pc = pc + 1;
        uc[pc] = mk(OP_SQA, 0, RA_F1 + 1, RA_F1 + 1); pc = pc + 1;
        uc[pc] = mk(OP_SQA, 0, RA_F1 + 2, RA_F1 + 2); pc = pc + 1;
        uc[pc] = mk(OP_SQRT, RA_N1, 0, 0); pc = pc + 1;
        uc[pc] = mk(OP_SQ0, 0, RA_F2, RA_F2); pc = pc + 1;
        uc[pc] = mk(OP_SQA, 0, RA_F2 + 1, RA_F2 + 1); pc = pc + 1;
        uc[pc] = mk(OP_SQA, 0, RA_F2 + 2, RA_F2 + 2); pc = pc + 1;
        uc[pc] = mk(OP_SQRT, RA_N2, 0, 0); pc = pc + 1;
        // constraints
        uc[pc] = mk(OP_SUB, RA_T1, RA_N1, RA_SU); pc = pc + 1;
        uc[pc] = mk(OP_MUL, RA_C0, RA_AREA, RA_T1); pc = pc + 1;
        uc[pc] = mk(OP_SUB, RA_T1, RA_N2, RA_SV); pc = pc + 1;
        uc[pc] = mk(OP_MUL, RA_C1, RA_AREA, RA_T1); pc = pc + 1;
        uc[pc] = mk(OP_MUL, RA_T1, RA_F1, RA_F2); pc = pc + 1;
        uc[pc] = mk(OP_MUL, RA_T2, RA_F1 + 1, RA_F2 + 1); pc = pc + 1;
        uc[pc] = mk(OP_ADD, RA_DOT, RA_T1, RA_T2); pc = pc + 1;
        uc[pc] = mk(OP_MUL, RA_T1, RA_F1 + 2, RA_F2 + 2); pc = pc + 1;
        uc[pc] = mk(OP_ADD, RA_DOT, RA_DOT, RA_T1); pc = pc + 1;
        uc[pc] = mk(OP_MUL, RA_C2, RA_AREA, RA_DOT); pc = pc + 1;
        // unit vectors
        for (int i = 0; i < 3; i++) begin
            uc[pc] = mk(OP_DIV, RA_U1 + i, RA_F1 + i, RA_N1); pc = pc + 1;
        end
        for (int i = 0; i < 3; i++) begin
            uc[pc] = mk(OP_DIV, RA_U2 + i, RA_F2 + i, RA_N2); pc = pc + 1;
        end
        // stiffness scaled coefficients
        uc[pc] = mk(OP_MUL, RA_T1, RA_KS, RA_C0); pc = pc + 1;
        uc[pc] = mk(OP_MUL, RA_CS0, RA_T1, RA_AREA); pc = pc + 1;
        uc[pc] = mk(OP_MUL, RA_T1, RA_KS, RA_C1); pc = pc + 1;
        uc[pc] = mk(OP_MUL, RA_CS1, RA_T1, RA_AREA); pc = pc + 1;
        uc[pc] = mk(OP_MUL, RA_T1, RA_KH, RA_C2); pc = pc + 1;
        uc[pc] = mk(OP_MUL, RA_CH, RA_T1, RA_AREA); pc = pc + 1;
        // gradient with respect to the columns
        for (int i = 0; i < 3; i++) begin
            uc[pc] = mk(OP_MUL, RA_T1, RA_CS0, RA_U1 + i); pc = pc + 1;
            uc[pc] = mk(OP_MUL, RA_T2, RA_CH, RA_F2 + i); pc = pc + 1;
            uc[pc] = mk(OP_ADD, RA_G1 + i, RA_T1, RA_T2); pc = pc + 1;
            uc[pc] = mk(OP_MUL, RA_T1, RA_CS1, RA_U2 + i); pc = pc + 1;
            uc[pc] = mk(OP_MUL, RA_T2, RA_CH, RA_F1 + i); pc = pc + 1;
            uc[pc] = mk(OP_ADD, RA_G2 + i, RA_T1, RA_T2); pc = pc + 1;
        end
        // per-vertex gradients
        for (int i = 0; i < 3; i++) begin
            uc[pc] = mk(OP_MUL, RA_T1, RA_I00, RA_G1 + i); pc = pc + 1;
            uc[pc] = mk(OP_MUL, RA_T2, RA_I01, RA_G2 + i); pc = pc + 1;
            uc[pc] = mk(OP_ADD, RA_GR1 + i, RA_T1, RA_T2); pc = pc + 1;
            uc[pc] = mk(OP_MUL, RA_T1, RA_I10, RA_G1 + i); pc = pc + 1;
            uc[pc] = mk(OP_MUL, RA_T2, RA_I11, RA_G2 + i); pc = pc + 1;
            uc[pc] = mk(OP_ADD, RA_GR2 + i, RA_T1, RA_T2); pc = pc + 1;
            uc[pc] = mk(OP_NSUB, RA_GR0 + i, RA_GR1 + i, RA_GR2 + i); pc = pc + 1;
        end
        return uc;
    endfunction

    localparam t_ucode UCODE = build_ucode();

endpackage

### hdl/tssg_if.sv
// Input and output channel interfaces of the gradient core.
// Handshake and payload fields; depends on nothing.
interface tssg_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        node;
    logic signed [31:0] inv_00;
    logic signed [31:0] inv_01;
    logic signed [31:0] inv_10;
    logic signed [31:0] inv_11;
    logic [30:0]        rest_area;
    logic               third_vertex;

    modport source (output valid, pos_x, pos_y, pos_z, node, inv_00, inv_01, inv_10,
                    inv_11, rest_area, third_vertex, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, node, inv_00, inv_01, inv_10,
                    inv_11, rest_area, third_vertex, output ready);
endinterface

interface tssg_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        out_node;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_z;
    logic               saturated;
    logic               last;

    modport source (output valid, out_node, grad_x, grad_y, grad_z, saturated, last,
                    input ready);
    modport sink   (input valid, out_node, grad_x, grad_y, grad_z, saturated, last,
                    output ready);
endinterface

### hdl/tssg_front.sv
// Front part: accepts vertex items, holds the first two vertices and
// hands a closed triangle to the job queue. Uses tssg_pkg and tssg_in_if.
module tssg_front
    import tssg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    tssg_in_if.sink     i_in,
    input  logic        i_q_full,
    output t_job        o_job,
    output logic        o_push
);

    logic [1:0][2:0][31:0] r_slot_pos;
    logic [1:0][15:0]      r_slot_node;
    logic [1:0]            r_count;
    logic                  acc;

    assign i_in.ready = !i_q_full;
    assign acc        = i_in.valid && i_in.ready;
    assign o_push     = acc && i_in.third_vertex;

    // Count held vertices; a closing item restarts the triangle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (acc) begin
            if (i_in.third_vertex) begin
                r_count <= '0;
            end else if (r_count < 2'd2) begin
                r_count <= r_count + 2'd1;
            end
        end
    end

    // Store an open vertex; extra open vertices are dropped
    always_ff @(posedge i_clk) begin
        if (acc && !i_in.third_vertex && r_count < 2'd2) begin
            r_slot_pos[r_count[0]]  <= {i_in.pos_z, i_in.pos_y, i_in.pos_x};
            r_slot_node[r_count[0]] <= i_in.node;
        end
    end

    // Assemble the triangle job
    always_comb begin
        o_job.pos[0] = r_slot_pos[0][0];
        o_job.pos[1] = r_slot_pos[0][1];
        o_job.pos[2] = r_slot_pos[0][2];
        o_job.pos[3] = r_slot_pos[1][0];
        o_job.pos[4] = r_slot_pos[1][1];
        o_job.pos[5] = r_slot_pos[1][2];
        o_job.pos[6] = i_in.pos_x;
        o_job.pos[7] = i_in.pos_y;
        o_job.pos[8] = i_in.pos_z;
        o_job.node   = {i_in.node, r_slot_node[1], r_slot_node[0]};
        o_job.inv    = {i_in.inv_11, i_in.inv_10, i_in.inv_01, i_in.inv_00};
        o_job.area   = i_in.rest_area;
    end

endmodule

### hdl/tssg_queue.sv
// Short job queue between the front and the back part.
// Uses tssg_pkg for the job type.
module tssg_queue
    import tssg_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_head,
    output logic o_valid,
    output logic o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_head  = r_mem[r_rp];
    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CW'(DEPTH));

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

### hdl/tssg_back.sv
// Back part: sequencer running the triangle program over a scratch register
// file, one multiplier, a root unit and a divider; drives the result channel.
// Uses tssg_pkg and tssg_out_if.
module tssg_back
    import tssg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_job        i_job,
    input  logic        i_job_valid,
    output logic        o_job_pop,
    tssg_out_if.source  o_out
);

    t_bstate r_state, n_state;
    t_upc    r_pc;
    t_uop    uop;

    logic [31:0]        r_rf [RF_DEPTH];
    logic signed [31:0] r_rd_a, r_rd_b;
    logic signed [63:0] r_prod;
    logic [63:0]        r_acc;
    logic [31:0]        r_root;
    logic [33:0]        r_rem;
    logic [5:0]         r_cnt;
    logic [47:0]        r_dnum;
    logic [30:0]        r_drem;
    logic [47:0]        r_quo;
    logic               r_dneg, r_dzero;
    logic               r_clip;
    logic [8:0][31:0]   r_grad;

    logic [2:0][2:0][31:0] r_res;
    logic [2:0][15:0]      r_res_node;
    logic                  r_res_clip;
    logic                  r_busy;
    logic [1:0]            r_vtx;

    logic        wr_en, clip_hit, pc_inc, emit_load, last_step;
    logic [31:0] wr_data, ld_data;
    logic [32:0] s_alu, s_mul, s_root, s_div;
    logic [47:0] rnd;
    logic [35:0] rt_rem2, rt_trial;
    logic        rt_ge;
    logic [31:0] rt_root;
    logic [31:0] dv_rem2;
    logic        dv_ge;
    logic [47:0] dv_quo;
    logic [31:0] dv_mag;
    logic [5:0]  gr_off;

    assign uop       = UCODE[r_pc];
    assign last_step = (r_cnt == '0);

    // Load source for program loads
    always_comb begin
        case (uop.dst)
            RA_I00:  ld_data = i_job.inv[0];
            RA_I01:  ld_data = i_job.inv[1];
            RA_I10:  ld_data = i_job.inv[2];
            RA_I11:  ld_data = i_job.inv[3];
            RA_AREA: ld_data = {1'b0, i_job.area};
            RA_SU:   ld_data = {1'b0, i_cfg.su};
            RA_SV:   ld_data = {1'b0, i_cfg.sv};
            RA_KS:   ld_data = {1'b0, i_cfg.ks};
            RA_KH:   ld_data = {1'b0, i_cfg.kh};
            default: ld_data = (uop.dst < RA_I00) ? i_job.pos[uop.dst[3:0]] : '0;
        endcase
    end

    // Adder, rounding of the product, root and divide steps
    always_comb begin
        case (uop.op)
            OP_ADD:  s_alu = sat32(49'(r_rd_a) + 49'(r_rd_b));
            OP_NSUB: s_alu = sat32(-49'(r_rd_a) - 49'(r_rd_b));
            default: s_alu = sat32(49'(r_rd_a) - 49'(r_rd_b));
        endcase
        rnd      = 48'((r_prod + 64'sd32768) >>> 16);
        s_mul    = sat32(49'($signed(rnd)));

        rt_rem2  = {r_rem, r_acc[63:62]};
        rt_trial = {2'b00, r_root, 2'b01};
        rt_ge    = (rt_rem2 >= rt_trial);
        rt_root  = {r_root[30:0], rt_ge};
        s_root   = sat32(49'({1'b0, rt_root}));

        dv_rem2  = {r_drem, r_dnum[47]};
        dv_ge    = (dv_rem2 >= {1'b0, r_rd_b[30:0]});
        dv_quo   = {r_quo[46:0], dv_ge};
        s_div    = r_dneg ? sat32(-49'({1'b0, dv_quo})) : sat32(49'({1'b0, dv_quo}));
        dv_mag   = r_rd_a[31] ? 32'(-r_rd_a) : 32'(r_rd_a);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE:  if (i_job_valid) n_state = BS_FETCH;
            BS_FETCH: begin
                if (uop.op == OP_END) begin
                    n_state = BS_DONE;
                end else if (uop.op != OP_LD) begin
                    n_state = BS_EXEC;
                end
            end
            BS_EXEC: begin
                case (uop.op)
                    OP_MUL, OP_SQ0, OP_SQA: n_state = BS_MULW;
                    OP_SQRT:                n_state = BS_SQRT;
                    OP_DIV:                 n_state = BS_DIV;
                    default:                n_state = BS_FETCH;
                endcase
            end
            BS_MULW:  n_state = BS_FETCH;
            BS_SQRT:  if (last_step) n_state = BS_FETCH;
            BS_DIV:   if (last_step) n_state = BS_FETCH;
            BS_DONE:  if (!r_busy) n_state = BS_IDLE;
            default:  n_state = BS_IDLE;
        endcase
    end

    // Write port, clip flag, program advance and hand-off
    always_comb begin
        wr_en     = 1'b0;
        wr_data   = '0;
        clip_hit  = 1'b0;
        pc_inc    = 1'b0;
        emit_load = 1'b0;
        o_job_pop = 1'b0;
        case (r_state)
            BS_FETCH: begin
                if (uop.op == OP_LD) begin
                    wr_en   = 1'b1;
                    wr_data = ld_data;
                    pc_inc  = 1'b1;
                end
            end
            BS_EXEC: begin
                if (uop.op == OP_ADD || uop.op == OP_SUB || uop.op == OP_NSUB) begin
                    wr_en    = 1'b1;
                    wr_data  = s_alu[31:0];
                    clip_hit = s_alu[32];
                    pc_inc   = 1'b1;
                end
            end
            BS_MULW: begin
                pc_inc = 1'b1;
                if (uop.op == OP_MUL) begin
                    wr_en    = 1'b1;
                    wr_data  = s_mul[31:0];
                    clip_hit = s_mul[32];
                end
            end
            BS_SQRT: begin
                if (last_step) begin
                    wr_en    = 1'b1;
                    wr_data  = s_root[31:0];
                    clip_hit = s_root[32];
                    pc_inc   = 1'b1;
                end
            end
            BS_DIV: begin
                if (last_step) begin
                    // zero-length column: no stretch direction
                    wr_en    = 1'b1;
                    wr_data  = r_dzero ? '0 : s_div[31:0];
                    clip_hit = !r_dzero && s_div[32];
                    pc_inc   = 1'b1;
                end
            end
            BS_DONE: begin
                emit_load = !r_busy;
                o_job_pop = !r_busy;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == BS_IDLE) begin
                r_pc <= '0;
            end else if (pc_inc) begin
                r_pc <= r_pc + t_upc'(1);
            end
        end
    end

    // Register file with registered reads
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_rf[uop.dst] <= wr_data;
        end
        r_rd_a <= r_rf[uop.a];
        r_rd_b <= r_rf[uop.b];
    end

    // Catch the vertex gradients as they are written
    assign gr_off = uop.dst - RA_GR1;
    always_ff @(posedge i_clk) begin
        if (wr_en && uop.dst >= RA_GR1 && uop.dst <= RA_GR0 + 6'd2) begin
            r_grad[gr_off[3:0]] <= wr_data;
        end
    end

    // Multiplier, square accumulator, root and divide units
    always_ff @(posedge i_clk) begin
        if (r_state == BS_IDLE) begin
            r_clip <= 1'b0;
        end else if (clip_hit) begin
            r_clip <= 1'b1;
        end
        case (r_state)
            BS_EXEC: begin
                r_prod  <= $signed(r_rd_a) * $signed(r_rd_b);
                r_root  <= '0;
                r_rem   <= '0;
                r_cnt   <= (uop.op == OP_DIV) ? 6'd47 : 6'd31;
                r_dnum  <= {dv_mag, 16'h0000};
                r_drem  <= '0;
                r_quo   <= '0;
                r_dneg  <= r_rd_a[31];
                r_dzero <= (r_rd_b == '0);
            end
            BS_MULW: begin
                if (uop.op == OP_SQ0) begin
                    r_acc <= r_prod;
                end else if (uop.op == OP_SQA) begin
                    r_acc <= r_acc + r_prod;
                end
            end
            BS_SQRT: begin
                r_acc  <= {r_acc[61:0], 2'b00};
                r_rem  <= rt_ge ? 34'(rt_rem2 - rt_trial) : rt_rem2[33:0];
                r_root <= rt_root;
                r_cnt  <= r_cnt - 6'd1;
            end
            BS_DIV: begin
                r_dnum <= {r_dnum[46:0], 1'b0};
                r_drem <= dv_ge ? 31'(dv_rem2 - {1'b0, r_rd_b[30:0]}) : dv_rem2[30:0];
                r_quo  <= dv_quo;
                r_cnt  <= r_cnt - 6'd1;
            end
            default: ;
        endcase
    end

    // Result emitter: three items per triangle, vertex 0 first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_vtx  <= '0;
        end else if (emit_load) begin
            r_busy <= 1'b1;
            r_vtx  <= '0;
        end else if (r_busy && o_out.ready) begin
            if (r_vtx == 2'd2) begin
                r_busy <= 1'b0;
            end
            r_vtx <= r_vtx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_res[0]   <= {r_grad[8], r_grad[7], r_grad[6]};
            r_res[1]   <= {r_grad[2], r_grad[1], r_grad[0]};
            r_res[2]   <= {r_grad[5], r_grad[4], r_grad[3]};
            r_res_node <= i_job.node;
            r_res_clip <= r_clip;
        end
    end

    assign o_out.valid     = r_busy;
    assign o_out.out_node  = r_res_node[r_vtx];
    assign o_out.grad_x    = r_res[r_vtx][0];
    assign o_out.grad_y    = r_res[r_vtx][1];
    assign o_out.grad_z    = r_res[r_vtx][2];
    assign o_out.saturated = r_res_clip;
    assign o_out.last      = (r_vtx == 2'd2);

endmodule

### hdl/triangle_stretch_shear_gradient_core.sv
// Triangle stretch/shear gradient core. An open vertex item is only held;
// a closing item's results are computed by the shared sequencer, which
// runs two 32-step roots and six 48-step divides. The back part takes one
// triangle at a time; the queue holds two triangles. Reset (synchronous,
// active low) clears the vertex count, queue, sequencer and emitter and
// sets all registers to 1.0.
module triangle_stretch_shear_gradient_core
    import tssg_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tssg_in_if.sink     i_in,
    tssg_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data
);

    t_cfg r_cfg;
    t_job f_job, q_head;
    logic f_push, q_valid, q_full, b_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{ks: CFG_ONE, kh: CFG_ONE, su: CFG_ONE, sv: CFG_ONE};
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_STRETCH_K: r_cfg.ks <= i_cfg_data;
                CFG_SHEAR_K:   r_cfg.kh <= i_cfg_data;
                CFG_REST_U:    r_cfg.su <= i_cfg_data;
                CFG_REST_V:    r_cfg.sv <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tssg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_job    (f_job),
        .o_push   (f_push)
    );

    tssg_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_job   (f_job),
        .i_pop   (b_pop),
        .o_head  (q_head),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    tssg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (q_head),
        .i_job_valid (q_valid),
        .o_job_pop   (b_pop),
        .o_out       (o_out)
    );

    // Back only retires a job that the queue holds
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_pop |-> q_valid)
        else $error("job retired from empty queue");

    // Emitter falls idle after the last item of a triangle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last) |=> !o_out.valid)
        else $error("result after last item of triangle");

    // Clip flag holds across a triangle's items
    a_clip_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last) |=>
            (o_out.valid && $stable(o_out.saturated)))
        else $error("saturation flag changed within a triangle");

endmodule

### dv/tssg_grad_checker.sv
// Watches the vertex, gradient and register ports of the gradient core,
// predicts each triangle's three results and compares them. Uses tssg_pkg and tssg_if.sv.
module tssg_grad_checker
    import tssg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    tssg_in_if    in_ch,
    tssg_out_if   out_ch,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data,
    output int    o_fails,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] node;
        logic [31:0] gx;
        logic [31:0] gy;
        logic [31:0] gz;
        logic        sat;
        logic        last;
    } t_grad;

    t_grad grad_expect_q[$];

    // Shadow state of the block
    longint      stretch_gain, k_shear, rest_u, rest_v;
    logic [31:0] held_pos[9];
    logic [15:0] held_node[3];
    int          held_cnt;
    bit          clipped;
    int          fails = 0;
    int          pend_cnt = 0;

    assign o_fails   = fails;
    assign o_pending = pend_cnt;

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) begin
            clipped = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            clipped = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Q16.16 product, rounded half up, saturated
    function automatic longint qprod(longint a, longint b);
        return clip32((a * b + 64'sd32768) >>> 16);
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint col_len(longint f[3]);
        longint unsigned s, m;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m = (f[i] < 0) ? -f[i] : f[i];
            s = s + m * m;
        end
        return clip32(longint'(root64(s)));
    endfunction

    // Close the triangle and queue the gradients of vertex 0, 1, 2
    task automatic predict_triangle(longint i00, longint i01, longint i10, longint i11,
                                    longint area);
        longint p[3][3];
        longint e1[3], e2[3], f1[3], f2[3], u1[3], u2[3], g1[3], g2[3], gr[3][3];
        longint n1, n2, c0, c1, c2, dp, cs0, cs1, ch;
        t_grad  r;
        clipped = 0;
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
                p[k][i] = longint'($signed(held_pos[k*3+i]));
        for (int i = 0; i < 3; i++) begin
            e1[i] = clip32(p[1][i] - p[0][i]);
            e2[i] = clip32(p[2][i] - p[0][i]);
        end
        for (int i = 0; i < 3; i++) begin
            f1[i] = clip32(qprod(e1[i], i00) + qprod(e2[i], i10));
            f2[i] = clip32(qprod(e1[i], i01) + qprod(e2[i], i11));
        end
        n1 = col_len(f1);
        n2 = col_len(f2);
        c0 = qprod(area, clip32(n1 - rest_u));
        c1 = qprod(area, clip32(n2 - rest_v));
        dp = clip32(qprod(f1[0], f2[0]) + qprod(f1[1], f2[1]));
        dp = clip32(dp + qprod(f1[2], f2[2]));
        c2 = qprod(area, dp);
        // a zero-length column has a zero unit vector
        for (int i = 0; i < 3; i++) begin
            u1[i] = (n1 == 0) ? 0 : clip32((f1[i] * 65536) / n1);
            u2[i] = (n2 == 0) ? 0 : clip32((f2[i] * 65536) / n2);
        end
        cs0 = qprod(qprod(stretch_gain, c0), area);
        cs1 = qprod(qprod(stretch_gain, c1), area);
        ch  = qprod(qprod(k_shear, c2), area);
        for (int i = 0; i < 3; i++) begin
            g1[i] = clip32(qprod(cs0, u1[i]) + qprod(ch, f2[i]));
            g2[i] = clip32(qprod(cs1, u2[i]) + qprod(ch, f1[i]));
        end
        for (int i = 0; i < 3; i++) begin
            gr[1][i] = clip32(qprod(i00, g1[i]) + qprod(i01, g2[i]));
            gr[2][i] = clip32(qprod(i10, g1[i]) + qprod(i11, g2[i]));
            gr[0][i] = clip32(-gr[1][i] - gr[2][i]);
        end
        for (int k = 0; k < 3; k++) begin
            r.node = held_node[k];
            r.gx   = gr[k][0][31:0];
            r.gy   = gr[k][1][31:0];
            r.gz   = gr[k][2][31:0];
            r.sat  = clipped;
            r.last = (k == 2);
            grad_expect_q = {grad_expect_q, r};
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_grad want;
        if (!i_rst_n) begin
            stretch_gain = 65536;
            k_shear      = 65536;
            rest_u       = 65536;
            rest_v       = 65536;
            held_cnt     = 0;
            grad_expect_q.delete();
        end else begin
            // track register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_STRETCH_K: stretch_gain = i_cfg_data;
                    CFG_SHEAR_K:   k_shear      = i_cfg_data;
                    CFG_REST_U:    rest_u       = i_cfg_data;
                    CFG_REST_V:    rest_v       = i_cfg_data;
                    default: ;
                endcase
            end
            // compare each gradient item with the oldest prediction
            if (out_ch.valid && out_ch.ready) begin
                if (grad_expect_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected gradient item, node %h", $time,
                             out_ch.out_node);
                end else begin
                    want = grad_expect_q.pop_front();
                    check_field("out_node", want.node, out_ch.out_node);
                    check_field("grad_x", want.gx, out_ch.grad_x);
                    check_field("grad_y", want.gy, out_ch.grad_y);
                    check_field("grad_z", want.gz, out_ch.grad_z);
                    check_field("saturated", want.sat, out_ch.saturated);
                    check_field("last", want.last, out_ch.last);
                end
            end
            // hold vertices; a marked item closes the triangle
            if (in_ch.valid && in_ch.ready) begin
                if (!in_ch.third_vertex) begin
                    if (held_cnt < 2) begin
                        held_pos[held_cnt*3+0] = in_ch.pos_x;
                        held_pos[held_cnt*3+1] = in_ch.pos_y;
                        held_pos[held_cnt*3+2] = in_ch.pos_z;
                        held_node[held_cnt]    = in_ch.node;
                        held_cnt++;
                    end
                end else begin
                    held_pos[6]  = in_ch.pos_x;
                    held_pos[7]  = in_ch.pos_y;
                    held_pos[8]  = in_ch.pos_z;
                    held_node[2] = in_ch.node;
                    held_cnt     = 0;
                    predict_triangle(longint'(in_ch.inv_00), longint'(in_ch.inv_01),
                                     longint'(in_ch.inv_10), longint'(in_ch.inv_11),
                                     longint'({1'b0, in_ch.rest_area}));
                end
            end
        end
        pend_cnt = grad_expect_q.size();
    end

endmodule

### dv/triangle_stretch_shear_gradient_core_tb.sv
// Stimulus and verdict for the triangle stretch/shear gradient core.
// Depends on tssg_pkg, tssg_if.sv, the core and dv/tssg_grad_checker.sv.
module triangle_stretch_shear_gradient_core_tb
    import tssg_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [30:0] cfg_data;
    int          fails;
    int          pending;
    bit          calm;

    tssg_in_if  in_ch ();
    tssg_out_if out_ch ();

    triangle_stretch_shear_gradient_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    tssg_grad_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_fails    (fails),
        .o_pending  (pending)
    );

    initial i_clk = 0;
    always #5 i_clk = ~i_clk;

    // Stall the result side about a third of the time unless calm
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= calm || ($urandom_range(0, 99) >= 33);
        end
    end

    // Hand one vertex item to the block, at times after a random gap unless calm
    task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic [15:0] nd, logic [31:0] a, logic [31:0] b,
                               logic [31:0] c, logic [31:0] d, logic [30:0] ar,
                               logic mark);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 33) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.pos_x        <= x;
        in_ch.pos_y        <= y;
        in_ch.pos_z        <= z;
        in_ch.node         <= nd;
        in_ch.inv_00       <= a;
        in_ch.inv_01       <= b;
        in_ch.inv_10       <= c;
        in_ch.inv_11       <= d;
        in_ch.rest_area    <= ar;
        in_ch.third_vertex <= mark;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
    endtask

    task automatic send_open(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [15:0] nd);
        send_vertex(x, y, z, nd, $urandom(), $urandom(), $urandom(), $urandom(),
                    31'($urandom()), 1'b0);
    endtask

    function automatic logic [31:0] near(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // Well-formed triangle with plausible geometry and random content
    task automatic send_triangle();
        logic [31:0] bx, by, bz;
        int          sh;
        sh = $urandom_range(0, 3) == 0 ? 22 : 18;
        bx = near(1 << 24);
        by = near(1 << 24);
        bz = near(1 << 24);
        send_open(bx, by, bz, 16'($urandom()));
        send_open(bx + near(1 << sh), by + near(1 << sh), bz + near(1 << sh),
                  16'($urandom()));
        send_vertex(bx + near(1 << sh), by + near(1 << sh), bz + near(1 << sh),
                    16'($urandom()), near(1 << 18), near(1 << 18), near(1 << 18),
                    near(1 << 18), 31'($urandom_range(0, 1 << 18)), 1'b1);
    endtask

    // Fully random item, mark chosen at random
    task automatic send_noise();
        send_vertex($urandom(), $urandom(), $urandom(), 16'($urandom()), $urandom(),
                    $urandom(), $urandom(), $urandom(), 31'($urandom()),
                    $urandom_range(0, 2) == 0);
    endtask

    // Wait for every gradient, then let open vertex work settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [30:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic write_all(logic [30:0] ks, logic [30:0] kh, logic [30:0] su,
                             logic [30:0] sv);
        write_cfg(CFG_STRETCH_K, ks);
        write_cfg(CFG_SHEAR_K, kh);
        write_cfg(CFG_REST_U, su);
        write_cfg(CFG_REST_V, sv);
    endtask

    task automatic random_phase(int count);
        int sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 75) begin
                send_triangle();
                n = n + 2;
            end else if (sel < 90) begin
                send_noise();
            end else begin
                // broken sequence: early mark or surplus open vertices
                if ($urandom_range(0, 1)) begin
                    send_open(near(1 << 20), near(1 << 20), near(1 << 20),
                              16'($urandom()));
                end else begin
                    repeat (3) send_open(near(1 << 20), near(1 << 20), near(1 << 20),
                                         16'($urandom()));
                end
                send_vertex(near(1 << 20), near(1 << 20), near(1 << 20), 16'($urandom()),
                            near(1 << 17), near(1 << 17), near(1 << 17), near(1 << 17),
                            31'($urandom_range(0, 1 << 17)), 1'b1);
                n = n + 2;
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        calm               = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = CFG_STRETCH_K;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.pos_x        = '0;
        in_ch.pos_y        = '0;
        in_ch.pos_z        = '0;
        in_ch.node         = '0;
        in_ch.inv_00       = '0;
        in_ch.inv_01       = '0;
        in_ch.inv_10       = '0;
        in_ch.inv_11       = '0;
        in_ch.rest_area    = '0;
        in_ch.third_vertex = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset registers, right triangle with identity inverse
        send_open(0, 0, 0, 16'h0000);
        send_open(32'h0001_8000, 0, 0, 16'h0001);
        send_vertex(0, 32'h0002_0000, 0, 16'hFFFF, 32'h0001_0000, 0, 0,
                    32'h0001_0000, 31'h0000_8000, 1'b1);
        // surplus open vertex is dropped
        send_open(32'h0000_1000, 32'h0000_2000, 0, 16'h1234);
        send_open(32'h0001_0000, 32'h0000_2000, 0, 16'h4321);
        send_open(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hAAAA);
        send_vertex(32'h0000_1000, 32'h0001_2000, 32'h0000_4000, 16'h5555,
                    32'h0001_0000, 32'h0000_4000, 32'hFFFF_C000, 32'h0001_0000,
                    31'h0001_0000, 1'b1);
        // zero-length columns: all vertices equal
        send_open(32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 16'h0010);
        send_open(32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 16'h0011);
        send_vertex(32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 16'h0012,
                    32'h0001_0000, 0, 0, 32'h0001_0000, 31'h7FFF_FFFF, 1'b1);
        // position and matrix extremes, forcing saturation
        send_open(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0020);
        send_open(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0021);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0022,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                    31'h7FFF_FFFF, 1'b1);
        // zero area, then an early mark on slots held from before
        send_open(32'h0001_0000, 0, 0, 16'h0030);
        send_vertex(0, 32'h0001_0000, 0, 16'h0031, 32'h0001_0000, 0, 0,
                    32'h0001_0000, 31'h0, 1'b1);
        send_vertex(0, 0, 32'h0001_0000, 16'h0032, 32'h0002_0000, 32'h0000_8000,
                    32'hFFFF_8000, 32'h0002_0000, 31'h0001_0000, 1'b1);
        drain();

        // Zero registers
        write_all(31'h0, 31'h0, 31'h0, 31'h0);
        random_phase(40);
        drain();

        // Largest registers
        write_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        random_phase(40);
        drain();

        // Random registers, first stretch without any stalls
        write_all(31'($urandom_range(0, 1 << 18)), 31'($urandom_range(0, 1 << 18)),
                  31'($urandom_range(0, 1 << 18)), 31'($urandom_range(0, 1 << 18)));
        calm = 1'b1;
        random_phase(60);
        calm = 1'b0;
        random_phase(60);
        drain();

        // Typical stiffness with rest stretch near one
        write_all(31'h0002_0000, 31'h0000_8000, 31'h0000_F000, 31'h0001_1000);
        random_phase(100);
        drain();

        if (fails == 0) begin
            $display("PASS triangle_stretch_shear_gradient_core");
        end else begin
            $display("FAIL triangle_stretch_shear_gradient_core");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("FAIL triangle_stretch_shear_gradient_core");
        $finish;
    end

endmodule

### triangle_stretch_shear_gradient_core.f
hdl/tssg_pkg.sv
hdl/tssg_if.sv
hdl/tssg_front.sv
hdl/tssg_queue.sv
hdl/tssg_back.sv
hdl/triangle_stretch_shear_gradient_core.sv
dv/tssg_grad_checker.sv
dv/triangle_stretch_shear_gradient_core_tb.sv
